@@ rtl/packed_sprite_rle_decoder_defines.svh @@
// Assertion macros for the packed sprite run-length decoder.
`ifndef PACKED_SPRITE_RLE_DECODER_DEFINES_SVH
`define PACKED_SPRITE_RLE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define PSRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset.
`define PSRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSRD_ASSERT_IMP(lbl, ante, cons, msg)
`define PSRD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/psrd_pkg.sv @@
// Shared types and constants of the packed sprite run-length decoder.
package psrd_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned RUN_W   = 6;

  // Request kinds on the input channel
  localparam logic CMD_STREAM  = 1'b0;
  localparam logic CMD_PALETTE = 1'b1;

  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_INDEX = 2'd1,
    MODE_PAIR  = 2'd2,
    MODE_ALPHA = 2'd3
  } run_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX,
    ST_ZERO
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic do_write;
    logic do_header;
    logic do_hold;
    logic do_read;
    logic do_skip;
    logic emit;
    logic emit_zero;
  } psrd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic      busy_left;
    logic      last;
    run_mode_e mode;
    logic      pair_phase;
    logic      hdr_count_zero;
    run_mode_e hdr_mode;
    logic      slot_free;
  } psrd_status_t;

endpackage

@@ rtl/psrd_ctrl.sv @@
// Sequencing state machine of the packed sprite run-length decoder.
module psrd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  command_i,
  input  psrd_pkg::psrd_status_t status_i,
  output logic                  in_stall_o,
  output psrd_pkg::psrd_cmd_t    cmd_o
);
  import psrd_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (command_i == CMD_STREAM)) begin
          if (!status_i.busy_left) begin
            if (!status_i.hdr_count_zero && (status_i.hdr_mode == MODE_ZERO)) begin
              state_d = ST_ZERO;
            end
          end else begin
            unique case (status_i.mode) inside
              MODE_INDEX, MODE_ALPHA: state_d = ST_PIX;
              MODE_PAIR: begin
                if (status_i.pair_phase) state_d = ST_PIX;
              end
              default: state_d = ST_IDLE;
            endcase
          end
        end
      end
      ST_PIX: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      ST_ZERO: begin
        if (status_i.slot_free && status_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == CMD_PALETTE) begin
            cmd_o.do_write = 1'b1;
          end else if (!status_i.busy_left) begin
            cmd_o.do_header = 1'b1;
          end else begin
            unique case (status_i.mode) inside
              MODE_INDEX, MODE_ALPHA: cmd_o.do_read = 1'b1;
              MODE_PAIR: begin
                if (status_i.pair_phase) cmd_o.do_read = 1'b1;
                else                     cmd_o.do_hold = 1'b1;
              end
              default: cmd_o.do_skip = 1'b1;
            endcase
          end
        end
      end
      ST_PIX:  cmd_o.emit      = status_i.slot_free;
      ST_ZERO: cmd_o.emit_zero = status_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/psrd_datapath.sv @@
// Palette memory, run state and output register of the sprite decoder.
module psrd_datapath #(
  parameter int unsigned PALETTE_DEPTH = psrd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psrd_pkg::IDX_W-1:0]        cfg_wdata_i,
  input  logic [psrd_pkg::IDX_W-1:0]        stream_byte_i,
  input  logic [psrd_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [psrd_pkg::COLOR_W-1:0]      entry_color_i,
  input  psrd_pkg::psrd_cmd_t               cmd_i,
  input  logic                              out_stall_i,
  output psrd_pkg::psrd_status_t            status_o,
  output logic                              out_valid_o,
  output logic [psrd_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                              end_of_run_o
);
  import psrd_pkg::*;

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

  run_mode_e          run_mode_q, run_mode_d;
  logic [RUN_W-1:0]   pixels_left_q, pixels_left_d;
  logic               pair_phase_q, pair_phase_d;
  logic [IDX_W-1:0]   held_index_q;
  logic [IDX_W-1:0]   default_index_q;
  logic [COLOR_W-1:0] rdata_q;
  logic [IDX_W-1:0]   alpha_q;
  logic               use_alpha_q;
  logic               in_range_q;
  logic               out_valid_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_end_q;

  logic [IDX_W-1:0]   rd_idx;
  logic               rd_use_alpha;
  logic               rd_in_range;
  logic               wr_in_range;
  logic [COLOR_W-1:0] pix_color;
  logic               slot_free;

  // Select the palette read address for the current run mode
  always_comb begin
    rd_idx       = stream_byte_i;
    rd_use_alpha = 1'b0;
    case (run_mode_q)
      MODE_PAIR: begin
        rd_idx       = held_index_q;
        rd_use_alpha = 1'b1;
      end
      MODE_ALPHA: begin
        rd_idx       = default_index_q;
        rd_use_alpha = 1'b1;
      end
      default: begin
        rd_idx       = stream_byte_i;
        rd_use_alpha = 1'b0;
      end
    endcase
  end

  assign rd_in_range = {1'b0, rd_idx} < (IDX_W + 1)'(PALETTE_DEPTH);
  assign wr_in_range = {1'b0, entry_index_i} < (IDX_W + 1)'(PALETTE_DEPTH);

  // Palette write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && wr_in_range) begin
      palette_mem[entry_index_i[AW-1:0]] <= entry_color_i;
    end
  end

  // Palette read port, registered, with the pixel's alpha alongside
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_read) begin
      rdata_q     <= palette_mem[rd_idx[AW-1:0]];
      alpha_q     <= stream_byte_i;
      use_alpha_q <= rd_use_alpha;
      in_range_q  <= rd_in_range;
    end
  end

  // Run state update
  always_comb begin
    run_mode_d    = run_mode_q;
    pixels_left_d = pixels_left_q;
    pair_phase_d  = pair_phase_q;
    if (cmd_i.do_header) begin
      run_mode_d    = run_mode_e'(stream_byte_i[1:0]);
      pixels_left_d = stream_byte_i[7:2];
      pair_phase_d  = 1'b0;
    end else if (cmd_i.do_hold) begin
      pair_phase_d = 1'b1;
    end else if (cmd_i.do_read) begin
      pair_phase_d = 1'b0;
    end else if (cmd_i.do_skip) begin
      pixels_left_d = '0;
    end else if (cmd_i.emit || cmd_i.emit_zero) begin
      pixels_left_d = pixels_left_q - RUN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q      <= MODE_ZERO;
      pixels_left_q   <= '0;
      pair_phase_q    <= 1'b0;
      held_index_q    <= '0;
      default_index_q <= '0;
    end else begin
      run_mode_q    <= run_mode_d;
      pixels_left_q <= pixels_left_d;
      pair_phase_q  <= pair_phase_d;
      if (cmd_i.do_hold) held_index_q <= stream_byte_i;
      if (cfg_we_i)      default_index_q <= cfg_wdata_i;
    end
  end

  // Form the pixel: entries beyond the palette read as zero
  always_comb begin
    pix_color = in_range_q ? rdata_q : '0;
    if (use_alpha_q) pix_color = {alpha_q, pix_color[COLOR_W-IDX_W-1:0]};
  end

  // Output register
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_zero) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.emit_zero) begin
      out_color_q <= cmd_i.emit ? pix_color : '0;
      out_end_q   <= (pixels_left_q == RUN_W'(1));
    end
  end

  // Status to the controller
  always_comb begin
    status_o.busy_left      = (pixels_left_q != '0);
    status_o.last           = (pixels_left_q == RUN_W'(1));
    status_o.mode           = run_mode_q;
    status_o.pair_phase     = pair_phase_q;
    status_o.hdr_count_zero = (stream_byte_i[7:2] == '0);
    status_o.hdr_mode       = run_mode_e'(stream_byte_i[1:0]);
    status_o.slot_free      = slot_free;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = out_color_q;
  assign end_of_run_o  = out_end_q;

endmodule

@@ rtl/packed_sprite_rle_decoder.sv @@
// Top level of the packed sprite run-length decoder: controller, datapath, assertions.
// A pixel byte's pixel passes the registered palette read, then the output register.
// After a palette pixel's byte the input stalls until that pixel is taken into the
// output register; zero runs give one pixel per cycle unless the output stalls.
// Reset: asynchronous, clears run state, default_index and output valid; palette keeps data.
`include "packed_sprite_rle_decoder_defines.svh"

module packed_sprite_rle_decoder #(
  parameter int unsigned PALETTE_DEPTH = psrd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psrd_pkg::IDX_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [psrd_pkg::IDX_W-1:0]    stream_byte_i,
  input  logic [psrd_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [psrd_pkg::COLOR_W-1:0]  entry_color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psrd_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic                          end_of_run_o
);
  import psrd_pkg::*;

  psrd_cmd_t    cmd;
  psrd_status_t status;

  psrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  psrd_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .stream_byte_i (stream_byte_i),
    .entry_index_i (entry_index_i),
    .entry_color_i (entry_color_i),
    .cmd_i         (cmd),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .pixel_color_o (pixel_color_o),
    .end_of_run_o  (end_of_run_o)
  );

  // Pixels are only emitted while the run still has pixels left
  `PSRD_ASSERT_IMP(a_emit_in_run, cmd.emit || cmd.emit_zero, status.busy_left, "emit outside a run")
  // A palette read holds off the next request while its pixel waits to be emitted
  `PSRD_ASSERT_NXT(a_read_blocks_input, cmd.do_read, in_stall_o, "request taken during pixel cycle")
  // Zero runs hold the input until their last pixel is out
  `PSRD_ASSERT_IMP(a_zero_run_stalls, status.busy_left && (status.mode == MODE_ZERO), in_stall_o, "request taken during zero run")

endmodule

@@ test/packed_sprite_rle_decoder_tb.sv @@
// Self-checking testbench for the packed sprite run-length decoder.
module packed_sprite_rle_decoder_tb;
  import psrd_pkg::*;

  localparam int unsigned PAL_DEPTH      = PALETTE_DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned QUIET_LIMIT    = 3000;
  localparam int unsigned TOTAL_REQUESTS = 430;

  typedef struct packed {
    logic [COLOR_W-1:0] rgba;
    logic               last;
  } pixel_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]     cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 command_i     = CMD_STREAM;
  logic [IDX_W-1:0]     stream_byte_i = '0;
  logic [IDX_W-1:0]     entry_index_i = '0;
  logic [COLOR_W-1:0]   entry_color_i = '0;
  logic                 out_stall_i   = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [COLOR_W-1:0]   pixel_color_o;
  logic                 end_of_run_o;

  // Decoder shadow state, updated on each accepted request
  logic [COLOR_W-1:0]   shadow_palette [PAL_DEPTH];
  run_mode_e            cur_mode;
  logic [RUN_W-1:0]     pix_left;
  logic                 pair_wait_alpha;
  logic [IDX_W-1:0]     held_index_q;
  logic [IDX_W-1:0]     default_index_q;

  pixel_t               pending_pixels [$];
  bit                   entry_loaded [PAL_DEPTH];
  logic [IDX_W-1:0]     loaded_entries [$];
  int unsigned          requests_sent = 0;
  int unsigned          error_count   = 0;
  int unsigned          quiet_cycles  = 0;
  int unsigned          hold_count    = 0;
  bit                   hold_armed    = 1'b0;
  bit                   steady        = 1'b0;

  packed_sprite_rle_decoder #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .stream_byte_i(stream_byte_i),
    .entry_index_i(entry_index_i),
    .entry_color_i(entry_color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_color_o(pixel_color_o),
    .end_of_run_o (end_of_run_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Entries beyond the palette read as zero
  function automatic logic [COLOR_W-1:0] palette_lookup(input logic [IDX_W-1:0] idx);
    if (idx < PAL_DEPTH) return shadow_palette[idx];
    return '0;
  endfunction

  // Append one predicted pixel behind the older ones
  task automatic queue_pixel(input pixel_t px);
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  task automatic push_pixel(input logic [COLOR_W-1:0] rgba);
    pix_left = pix_left - 1'b1;
    queue_pixel({rgba, pix_left == '0});
  endtask

  // Work out the pixels that one accepted request produces
  task automatic decode_request(input logic cmd, input logic [IDX_W-1:0] sbyte,
                                input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] rgba);
    logic [RUN_W-1:0]   count;
    logic [COLOR_W-1:0] base;
    if (cmd == CMD_PALETTE) begin
      if (idx < PAL_DEPTH) shadow_palette[idx] = rgba;
    end else if (pix_left == '0) begin
      // header byte: length in the upper six bits, mode in the lower two
      count = sbyte[7:2];
      cur_mode = run_mode_e'(sbyte[1:0]);
      pair_wait_alpha = 1'b0;
      if (cur_mode == MODE_ZERO) begin
        for (int k = 0; k < count; k++) begin
          queue_pixel({{COLOR_W{1'b0}}, k == count - 1});
        end
      end else begin
        pix_left = count;
      end
    end else begin
      case (cur_mode)
        MODE_INDEX: push_pixel(palette_lookup(sbyte));
        MODE_PAIR: begin
          if (!pair_wait_alpha) begin
            held_index_q = sbyte;
            pair_wait_alpha = 1'b1;
          end else begin
            pair_wait_alpha = 1'b0;
            base = palette_lookup(held_index_q);
            push_pixel({sbyte, base[23:0]});
          end
        end
        MODE_ALPHA: begin
          base = palette_lookup(default_index_q);
          push_pixel({sbyte, base[23:0]});
        end
        default: pix_left = '0;
      endcase
    end
  endtask

  // Offer one request, hold it until accepted, then predict its pixels
  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] sbyte,
                              input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] rgba);
    if (!steady) begin
      while ($urandom_range(99) < 15) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    stream_byte_i <= sbyte;
    entry_index_i <= idx;
    entry_color_i <= rgba;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_request(cmd, sbyte, idx, rgba);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [IDX_W-1:0] sbyte);
    send_request(CMD_STREAM, sbyte, IDX_W'($urandom), $urandom);
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] rgba);
    send_request(CMD_PALETTE, IDX_W'($urandom), idx, rgba);
    if (idx < PAL_DEPTH && !entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_entries.insert(loaded_entries.size(), idx);
    end
  endtask

  // Only entries already written may be read
  function automatic logic [IDX_W-1:0] pick_entry();
    return loaded_entries[$urandom_range(loaded_entries.size() - 1)];
  endfunction

  // Drop valid and wait until every pixel is out and the block has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_default_index(input logic [IDX_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    default_index_q = value;
  endtask

  // Send a header and a matching body with random content
  task automatic send_random_run(input int max_len);
    run_mode_e        mode;
    logic [RUN_W-1:0] count;
    mode = run_mode_e'(2'($urandom_range(3)));
    if ($urandom_range(11) == 0) count = RUN_W'($urandom_range(63));
    else count = RUN_W'($urandom_range(max_len, 1));
    send_byte({count, mode});
    if (mode != MODE_ZERO) begin
      for (int p = 0; p < count; p++) begin
        if ($urandom_range(19) == 0) write_entry(IDX_W'($urandom), $urandom);
        case (mode)
          MODE_INDEX: send_byte(pick_entry());
          MODE_PAIR: begin
            send_byte(pick_entry());
            if ($urandom_range(9) == 0) write_entry(pick_entry(), $urandom);
            send_byte(IDX_W'($urandom));
          end
          default: send_byte(IDX_W'($urandom));
        endcase
      end
    end
  endtask

  task automatic test_directed_cases();
    write_entry(8'h00, 32'h1122_3344);
    write_entry(8'hFF, 32'hFFFF_FFFF);
    // zero length headers emit nothing
    send_byte({6'd0, MODE_INDEX});
    send_byte({6'd0, MODE_ZERO});
    // longest and shortest transparent runs
    send_byte({6'd63, MODE_ZERO});
    send_byte({6'd1, MODE_ZERO});
    send_byte({6'd2, MODE_INDEX});
    send_byte(8'hFF);
    send_byte(8'h00);
    // palette rewrite between index and alpha shows in the pixel
    send_byte({6'd2, MODE_PAIR});
    send_byte(8'hFF);
    write_entry(8'hFF, 32'h00A0_B0C0);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte({6'd2, MODE_ALPHA});
    send_byte(8'hFF);
    send_byte(8'h00);
    set_default_index(8'hFF);
    send_byte({6'd1, MODE_ALPHA});
    send_byte(8'h80);
  endtask

  // Hold the pixel side off while requests keep coming
  task automatic test_backpressure();
    hold_armed = 1'b1;
    repeat (3) send_byte({6'd63, MODE_ZERO});
    send_byte({6'd4, MODE_INDEX});
    repeat (4) send_byte(pick_entry());
    repeat (2) send_random_run(8);
  endtask

  task automatic test_steady_stream();
    int unsigned goal;
    goal = requests_sent + 60;
    steady = 1'b1;
    while (requests_sent < goal) send_random_run(6);
    steady = 1'b0;
  endtask

  task automatic test_random_runs();
    int unsigned goal;
    for (int phase = 0; phase < 6; phase++) begin
      set_default_index(phase == 0 ? 8'h00 : pick_entry());
      // share what is left of the request budget among the remaining phases
      goal = requests_sent;
      if (requests_sent < TOTAL_REQUESTS) begin
        goal = requests_sent + (TOTAL_REQUESTS - requests_sent) / (6 - phase);
      end
      while (requests_sent < goal) begin
        case ($urandom_range(19))
          0: write_entry(IDX_W'($urandom), $urandom);
          1: send_byte({6'd0, 2'($urandom_range(3))});
          default: send_random_run(8);
        endcase
      end
    end
  endtask

  // Pixel side: random stalls, a long hold-off on request, none while steady
  always @(posedge clk_i) begin
    if (hold_armed) begin
      hold_count = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 15);
    end
  end

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, got color %h end_of_run %b",
                 $time, pixel_color_o, end_of_run_o);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_color_o !== want.rgba) begin
          $display("%0t: pixel_color mismatch: expected %h, got %h",
                   $time, want.rgba, pixel_color_o);
          error_count++;
        end
        if (end_of_run_o !== want.last) begin
          $display("%0t: end_of_run mismatch: expected %b, got %b",
                   $time, want.last, end_of_run_o);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles, %0d pixels pending",
               $time, quiet_cycles, pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cur_mode        = MODE_ZERO;
    pix_left        = '0;
    pair_wait_alpha = 1'b0;
    held_index_q    = '0;
    default_index_q = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_backpressure();
    test_steady_stream();
    test_random_runs();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
